@@ hw/rtl/kdt_pkg.sv @@
`timescale 1ns / 1ps

package kdt_pkg;

	// table geometry
	localparam int TABLE_ENTRIES = 8;
	localparam int MAX_ORDER = 3;
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int WORDS = TABLE_ENTRIES * MAX_ORDER;
	localparam int WADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;

	// field widths
	localparam int KEY_W = 32;
	localparam int ORDER_W = 3;
	localparam int VALUE_W = 64;
	localparam int STATUS_W = 2;
	localparam int SLOT_W = 3;
	localparam int CFG_W = 4;

	// register port
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;
	localparam logic REG_ENTRIES_IN_USE = 1'b0;
	localparam logic [CFG_W-1:0] ENTRIES_IN_USE_RESET = 4'd8;

	// action codes
	localparam logic ACT_SET = 1'b0;
	localparam logic ACT_CLEAR = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_BAD_ORDER = 2'd1,
		ST_NO_ROOM   = 2'd2,
		ST_SKIPPED   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CHECK,
		S_SCAN,
		S_FINISH
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic    load;
		logic    clear_table;
		logic    scan_init;
		logic    scan_step;
		logic    wr_hit;
		logic    wr_alloc;
		logic    res_load;
		status_t res_status;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic action;
		logic skip;
		logic order_ok;
		logic scan_end;
		logic hit;
		logic free_found;
	} stat_t;

endpackage

@@ hw/rtl/kdt_if.sv @@
`timescale 1ns / 1ps

// input word channel
interface kdt_item_if;
	logic                         valid;
	logic                         ready;
	logic                         action;
	logic [kdt_pkg::KEY_W-1:0]    key;
	logic [kdt_pkg::ORDER_W-1:0]  order;
	logic [kdt_pkg::VALUE_W-1:0]  value;
	logic                         last_of_call;

	modport source (output valid, action, key, order, value, last_of_call, input ready);
	modport sink (input valid, action, key, order, value, last_of_call, output ready);
endinterface

// result word channel
interface kdt_result_if;
	logic                         valid;
	logic                         ready;
	logic [kdt_pkg::STATUS_W-1:0] status;
	logic [kdt_pkg::SLOT_W-1:0]   slot;
	logic                         newly_allocated;

	modport source (output valid, status, slot, newly_allocated, input ready);
	modport sink (input valid, status, slot, newly_allocated, output ready);
endinterface

@@ hw/rtl/kdt_ctrl.sv @@
`timescale 1ns / 1ps

module kdt_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_ready,
	output logic           result_valid,
	input  logic           result_ready,
	output kdt_pkg::cmd_t  cmd,
	input  kdt_pkg::stat_t st
);

	kdt_pkg::state_t  state_q, state_d;
	kdt_pkg::status_t status_q, status_d;
	logic             out_vld_q, out_vld_d;

	// state, status and output valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= kdt_pkg::S_IDLE;
			status_q  <= kdt_pkg::ST_OK;
			out_vld_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			status_q  <= status_d;
			out_vld_q <= out_vld_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d        = state_q;
		status_d       = status_q;
		cmd            = '0;
		cmd.res_status = status_q;
		item_ready     = (state_q == kdt_pkg::S_IDLE);
		unique case (state_q)
			kdt_pkg::S_IDLE: begin
				if (item_valid) begin
					cmd.load = 1'b1;
					state_d  = kdt_pkg::S_CHECK;
				end
			end
			kdt_pkg::S_CHECK: begin
				if (st.action == kdt_pkg::ACT_CLEAR) begin
					cmd.clear_table = 1'b1;
					status_d        = kdt_pkg::ST_OK;
					state_d         = kdt_pkg::S_FINISH;
				end else if (st.skip) begin
					status_d = kdt_pkg::ST_SKIPPED;
					state_d  = kdt_pkg::S_FINISH;
				end else if (!st.order_ok) begin
					status_d = kdt_pkg::ST_BAD_ORDER;
					state_d  = kdt_pkg::S_FINISH;
				end else begin
					cmd.scan_init = 1'b1;
					state_d       = kdt_pkg::S_SCAN;
				end
			end
			kdt_pkg::S_SCAN: begin
				if (st.scan_end) begin
					if (st.free_found) begin
						cmd.wr_alloc = 1'b1;
						status_d     = kdt_pkg::ST_OK;
					end else begin
						status_d = kdt_pkg::ST_NO_ROOM;
					end
					state_d = kdt_pkg::S_FINISH;
				end else if (st.hit) begin
					cmd.wr_hit = 1'b1;
					status_d   = kdt_pkg::ST_OK;
					state_d    = kdt_pkg::S_FINISH;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			kdt_pkg::S_FINISH: begin
				if (!out_vld_q || result_ready) begin
					cmd.res_load = 1'b1;
					state_d      = kdt_pkg::S_IDLE;
				end
			end
			default: state_d = kdt_pkg::S_IDLE;
		endcase
	end

	// output register valid
	always_comb begin
		if (cmd.res_load) begin
			out_vld_d = 1'b1;
		end else if (result_ready) begin
			out_vld_d = 1'b0;
		end else begin
			out_vld_d = out_vld_q;
		end
	end

	assign result_valid = out_vld_q;

`ifndef SYNTHESIS
	a_accept_to_check: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && item_ready) |=> (state_q == kdt_pkg::S_CHECK))
		else $error("accepted word did not move to check");
	a_load_fills_output: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |=> out_vld_q)
		else $error("result load did not set output valid");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.res_load && out_vld_q) |-> result_ready)
		else $error("result overwritten before taken");
`endif

endmodule

@@ hw/rtl/kdt_dp.sv @@
`timescale 1ns / 1ps

module kdt_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  kdt_pkg::cmd_t                 cmd,
	output kdt_pkg::stat_t                st,
	input  logic                          item_action,
	input  logic [kdt_pkg::KEY_W-1:0]     item_key,
	input  logic [kdt_pkg::ORDER_W-1:0]   item_order,
	input  logic [kdt_pkg::VALUE_W-1:0]   item_value,
	input  logic                          item_last,
	input  logic [kdt_pkg::CFG_W-1:0]     entries_in_use,
	output logic [kdt_pkg::STATUS_W-1:0]  res_status,
	output logic [kdt_pkg::SLOT_W-1:0]    res_slot,
	output logic                          res_newly
);

	// held word
	logic                         act_q;
	logic [kdt_pkg::KEY_W-1:0]    key_q;
	logic [kdt_pkg::ORDER_W-1:0]  order_q;
	logic [kdt_pkg::VALUE_W-1:0]  value_q;
	logic                         last_q;
	logic                         skip_q;

	// scan state
	logic [kdt_pkg::CNT_W-1:0]    cnt_q;
	logic                         free_found_q;
	logic [kdt_pkg::IDX_W-1:0]    free_idx_q;
	logic [kdt_pkg::SLOT_W-1:0]   sel_slot_q;
	logic                         sel_new_q;

	// table storage
	logic [kdt_pkg::KEY_W-1:0]    entry_key_q [kdt_pkg::TABLE_ENTRIES];
	logic [kdt_pkg::TABLE_ENTRIES-1:0] entry_vld_q;
	logic [kdt_pkg::VALUE_W-1:0]  word_q [kdt_pkg::WORDS];
	logic [kdt_pkg::WORDS-1:0]    word_vld_q;

	// result register
	logic [kdt_pkg::STATUS_W-1:0] res_status_q;
	logic [kdt_pkg::SLOT_W-1:0]   res_slot_q;
	logic                         res_new_q;

	logic [kdt_pkg::CNT_W-1:0]    limit;
	logic [kdt_pkg::IDX_W-1:0]    idx;
	logic [kdt_pkg::IDX_W-1:0]    wr_entry;
	logic [kdt_pkg::WADDR_W-1:0]  waddr;
	logic                         scan_end;
	logic                         hit;
	logic                         err;

	// usable entry count, capped at table size
	always_comb begin
		if (int'(entries_in_use) > kdt_pkg::TABLE_ENTRIES) begin
			limit = kdt_pkg::CNT_W'(kdt_pkg::TABLE_ENTRIES);
		end else begin
			limit = kdt_pkg::CNT_W'(entries_in_use);
		end
	end

	// compare at the scan pointer
	assign idx      = cnt_q[kdt_pkg::IDX_W-1:0];
	assign scan_end = (cnt_q >= limit);
	assign hit      = !scan_end && entry_vld_q[idx] && (entry_key_q[idx] == key_q);
	assign wr_entry = cmd.wr_alloc ? free_idx_q : idx;
	assign waddr    = kdt_pkg::WADDR_W'(int'(wr_entry) * kdt_pkg::MAX_ORDER
		+ int'(order_q) - 1);

	assign st.action     = act_q;
	assign st.skip       = skip_q;
	assign st.order_ok   = (order_q != '0) &&
		(order_q <= kdt_pkg::ORDER_W'(kdt_pkg::MAX_ORDER));
	assign st.scan_end   = scan_end;
	assign st.hit        = hit;
	assign st.free_found = free_found_q;

	assign err = (cmd.res_status == kdt_pkg::ST_BAD_ORDER) ||
		(cmd.res_status == kdt_pkg::ST_NO_ROOM);

	// capture the accepted word
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q   <= item_action;
			key_q   <= item_key;
			order_q <= item_order;
			value_q <= item_value;
			last_q  <= item_last;
		end
	end

	// skip mode across a call
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_q <= 1'b0;
		end else if (cmd.res_load) begin
			if (last_q) begin
				skip_q <= 1'b0;
			end else if (err) begin
				skip_q <= 1'b1;
			end else if (act_q == kdt_pkg::ACT_CLEAR) begin
				skip_q <= 1'b0;
			end
		end
	end

	// scan pointer and first free entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			free_found_q <= 1'b0;
			free_idx_q   <= '0;
		end else if (cmd.scan_init) begin
			cnt_q        <= '0;
			free_found_q <= 1'b0;
		end else if (cmd.scan_step) begin
			cnt_q <= cnt_q + 1'b1;
			if (!entry_vld_q[idx] && !free_found_q) begin
				free_found_q <= 1'b1;
				free_idx_q   <= idx;
			end
		end
	end

	// chosen slot for the result
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sel_slot_q <= '0;
			sel_new_q  <= 1'b0;
		end else if (cmd.wr_hit || cmd.wr_alloc) begin
			sel_slot_q <= kdt_pkg::SLOT_W'(wr_entry);
			sel_new_q  <= cmd.wr_alloc;
		end
	end

	// entry keys
	always_ff @(posedge clk) begin
		if (cmd.wr_alloc) begin
			entry_key_q[free_idx_q] <= key_q;
		end
	end

	// entry valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_vld_q <= '0;
		end else if (cmd.clear_table) begin
			entry_vld_q <= '0;
		end else if (cmd.wr_alloc) begin
			entry_vld_q[free_idx_q] <= 1'b1;
		end
	end

	// derivative words, one write port
	always_ff @(posedge clk) begin
		if (cmd.wr_hit || cmd.wr_alloc) begin
			word_q[waddr] <= value_q;
		end
	end

	// word valid bits
	// a claimed entry keeps only the word just written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_vld_q <= '0;
		end else if (cmd.clear_table) begin
			word_vld_q <= '0;
		end else if (cmd.wr_alloc) begin
			for (int n = 0; n < kdt_pkg::MAX_ORDER; n++) begin
				word_vld_q[kdt_pkg::WADDR_W'(int'(free_idx_q) * kdt_pkg::MAX_ORDER + n)] <=
					(n == int'(order_q) - 1);
			end
		end else if (cmd.wr_hit) begin
			word_vld_q[waddr] <= 1'b1;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			res_status_q <= cmd.res_status;
			res_slot_q   <= sel_slot_q;
			res_new_q    <= sel_new_q;
		end
	end

	assign res_status = res_status_q;
	assign res_slot   = res_slot_q;
	assign res_newly  = res_new_q;

`ifndef SYNTHESIS
	a_alloc_needs_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_alloc |-> (free_found_q && scan_end && !entry_vld_q[free_idx_q]))
		else $error("allocation without a free entry");
	a_hit_is_match: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_hit |-> (hit && !cmd.wr_alloc))
		else $error("hit write without a matching key");
	a_alloc_marks_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_alloc |=> entry_vld_q[$past(free_idx_q)])
		else $error("claimed entry not marked valid");
`endif

endmodule

@@ hw/rtl/keyed_derivative_table_unit.sv @@
`timescale 1ns / 1ps

// channel   dir  handshake       word
// item      in   valid / ready   action, key, order, value, last_of_call
// result    out  valid / ready   status, slot, newly_allocated
// apb       in   psel / penable  entries_in_use at byte address 0
//
// a set word that hits entry j ends its scan at entry j; a miss scans every entry up to the
// limit (limit is entries_in_use capped at 8)
// clear, skipped and bad order words go from check straight to finish, with no scan
// the scan visits one entry key per cycle, tracking the first free entry
// reset empties the table and skip mode at once, no clearing pass
// the result register lets the next word enter while a result waits;
// a second result waits in the controller until the first is taken
module keyed_derivative_table_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	kdt_item_if.sink                    item,
	kdt_result_if.source                result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [kdt_pkg::APB_AW-1:0]  paddr,
	input  logic [kdt_pkg::APB_DW-1:0]  pwdata,
	output logic [kdt_pkg::APB_DW-1:0]  prdata,
	output logic                        pready
);

	logic [kdt_pkg::CFG_W-1:0] entries_q;
	logic                      reg_sel;
	kdt_pkg::cmd_t             cmd;
	kdt_pkg::stat_t            st;

	// register decode
	assign pready  = 1'b1;
	assign reg_sel = (paddr[2] == kdt_pkg::REG_ENTRIES_IN_USE) && (paddr[1:0] == 2'b00);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_q <= kdt_pkg::ENTRIES_IN_USE_RESET;
		end else if (psel && penable && pwrite && reg_sel) begin
			entries_q <= pwdata[kdt_pkg::CFG_W-1:0];
		end
	end

	assign prdata = reg_sel ? kdt_pkg::APB_DW'(entries_q) : '0;

	kdt_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item.valid),
		.item_ready   (item.ready),
		.result_valid (result.valid),
		.result_ready (result.ready),
		.cmd          (cmd),
		.st           (st)
	);

	kdt_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.st             (st),
		.item_action    (item.action),
		.item_key       (item.key),
		.item_order     (item.order),
		.item_value     (item.value),
		.item_last      (item.last_of_call),
		.entries_in_use (entries_q),
		.res_status     (result.status),
		.res_slot       (result.slot),
		.res_newly      (result.newly_allocated)
	);

endmodule
